// File: hdl/cau_pkg.sv
package cau_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;

  // Per-request control flags that travel beside the magnitudes
  typedef struct packed {
    logic is_div;
    logic zero;
    logic neg_re;
    logic neg_im;
    logic ovf_re;
    logic ovf_im;
  } ctl_t;

endpackage

// File: hdl/cau_if.sv
interface cau_req_if #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   kind;
  logic signed [DATA_WIDTH-1:0] a_re;
  logic signed [DATA_WIDTH-1:0] a_im;
  logic signed [DATA_WIDTH-1:0] b_re;
  logic signed [DATA_WIDTH-1:0] b_im;

  modport source (output valid, kind, a_re, a_im, b_re, b_im, input ready);
  modport sink   (input valid, kind, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_rsp_if #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] res_re;
  logic signed [DATA_WIDTH-1:0] res_im;
  logic [1:0]                   status;

  modport source (output valid, res_re, res_im, status, input ready);
  modport sink   (input valid, res_re, res_im, status, output ready);
endinterface

// File: hdl/cau_front.sv
module cau_front #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    kind,
  input  logic signed [DATA_WIDTH-1:0]  a_re,
  input  logic signed [DATA_WIDTH-1:0]  a_im,
  input  logic signed [DATA_WIDTH-1:0]  b_re,
  input  logic signed [DATA_WIDTH-1:0]  b_im,
  output logic                          out_valid,
  input  logic                          out_ready,
  output cau_pkg::ctl_t                 ctl,
  output logic [2*DATA_WIDTH-1:0]       mag_re,
  output logic [2*DATA_WIDTH-1:0]       mag_im,
  output logic [2*DATA_WIDTH-1:0]       den
);
  localparam int PW = 2 * DATA_WIDTH;
  localparam int SW = 2 * DATA_WIDTH + 1;

  // stage A: products
  logic                  va;
  cau_pkg::op_t          op_a;
  logic signed [DATA_WIDTH-1:0] ar_a, ai_a, br_a, bi_a;
  logic signed [PW-1:0]  p_rr, p_ii, p_ri, p_ir, p_br2, p_bi2;
  logic                  rdy_a, rdy_b;

  // stage B: sums, sign and magnitude
  logic                  vb;
  logic signed [SW-1:0]  s_re, s_im;
  logic                  n_re, n_im;
  logic [PW-1:0]         m_re, m_im, d_sum;
  logic                  is_div;

  assign rdy_b    = !vb || out_ready;
  assign rdy_a    = !va || rdy_b;
  assign in_ready = rdy_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (rdy_a) begin
      va <= in_valid;
    end
    if (rdy_a && in_valid) begin
      op_a  <= cau_pkg::op_t'(kind);
      ar_a  <= a_re;
      ai_a  <= a_im;
      br_a  <= b_re;
      bi_a  <= b_im;
      p_rr  <= a_re * b_re;
      p_ii  <= a_im * b_im;
      p_ri  <= a_re * b_im;
      p_ir  <= a_im * b_re;
      p_br2 <= b_re * b_re;
      p_bi2 <= b_im * b_im;
    end
  end

  always_comb begin
    unique case (op_a)
      cau_pkg::OP_ADD: begin
        s_re = SW'(ar_a) + SW'(br_a);
        s_im = SW'(ai_a) + SW'(bi_a);
      end
      cau_pkg::OP_SUB: begin
        s_re = SW'(ar_a) - SW'(br_a);
        s_im = SW'(ai_a) - SW'(bi_a);
      end
      cau_pkg::OP_MUL: begin
        s_re = SW'(p_rr) - SW'(p_ii);
        s_im = SW'(p_ri) + SW'(p_ir);
      end
      default: begin
        s_re = SW'(p_rr) + SW'(p_ii);
        s_im = SW'(p_ir) - SW'(p_ri);
      end
    endcase
    n_re  = s_re[SW-1];
    n_im  = s_im[SW-1];
    m_re  = n_re ? PW'(-s_re) : PW'(s_re);
    m_im  = n_im ? PW'(-s_im) : PW'(s_im);
    // multiply truncates the magnitude, i.e. toward zero
    if (op_a == cau_pkg::OP_MUL) begin
      m_re = m_re >> FRAC_BITS;
      m_im = m_im >> FRAC_BITS;
    end
    d_sum  = PW'(p_br2) + PW'(p_bi2);
    is_div = (op_a == cau_pkg::OP_DIV);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (rdy_b) begin
      vb <= va;
    end
    if (rdy_b && va) begin
      ctl.is_div <= is_div;
      ctl.zero   <= is_div && (d_sum == '0);
      ctl.neg_re <= n_re;
      ctl.neg_im <= n_im;
      ctl.ovf_re <= 1'b0;
      ctl.ovf_im <= 1'b0;
      mag_re     <= m_re;
      mag_im     <= m_im;
      den        <= d_sum;
    end
  end

  assign out_valid = vb;

endmodule

// File: hdl/cau_div.sv
module cau_div #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  cau_pkg::ctl_t           in_ctl,
  input  logic [2*DATA_WIDTH-1:0] in_mag_re,
  input  logic [2*DATA_WIDTH-1:0] in_mag_im,
  input  logic [2*DATA_WIDTH-1:0] in_den,
  output logic                    out_valid,
  input  logic                    out_ready,
  output cau_pkg::ctl_t           out_ctl,
  output logic [2*DATA_WIDTH-1:0] out_q_re,
  output logic [2*DATA_WIDTH-1:0] out_q_im
);
  localparam int PW = 2 * DATA_WIDTH;
  localparam int EW = 3 * DATA_WIDTH + FRAC_BITS + 2;
  localparam int NS = DATA_WIDTH + 2;

  logic          v   [NS];
  logic          rdy [NS+1];
  cau_pkg::ctl_t ctl [NS];
  logic [EW-1:0] rem_re [NS];
  logic [EW-1:0] rem_im [NS];
  logic [PW-1:0] q_re [NS];
  logic [PW-1:0] q_im [NS];
  logic [PW-1:0] dv   [NS];

  logic [EW-1:0] d_re0, d_im0, lim0;
  cau_pkg::ctl_t ctl0;

  assign rdy[NS]  = out_ready;
  assign in_ready = rdy[0];

  // entry stage: scale dividend, flag quotients past W+1 bits
  assign d_re0 = EW'(in_mag_re) << FRAC_BITS;
  assign d_im0 = EW'(in_mag_im) << FRAC_BITS;
  assign lim0  = EW'(in_den) << (DATA_WIDTH + 1);

  always_comb begin
    ctl0        = in_ctl;
    ctl0.ovf_re = in_ctl.is_div && (d_re0 >= lim0);
    ctl0.ovf_im = in_ctl.is_div && (d_im0 >= lim0);
  end

  assign rdy[0] = !v[0] || rdy[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (rdy[0]) begin
      v[0] <= in_valid;
    end
    if (rdy[0] && in_valid) begin
      ctl[0]        <= ctl0;
      rem_re[0]     <= d_re0;
      rem_im[0]     <= d_im0;
      q_re[0]       <= in_ctl.is_div ? '0 : in_mag_re;
      q_im[0]       <= in_ctl.is_div ? '0 : in_mag_im;
      dv[0]         <= in_den;
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar k = 1; k < NS; k++) begin : g_step
    localparam int BIT = DATA_WIDTH + 1 - k;
    logic [EW-1:0] t;
    logic          take_re, take_im;

    assign t       = EW'(dv[k-1]) << BIT;
    assign take_re = ctl[k-1].is_div && !ctl[k-1].ovf_re && (rem_re[k-1] >= t);
    assign take_im = ctl[k-1].is_div && !ctl[k-1].ovf_im && (rem_im[k-1] >= t);
    assign rdy[k]  = !v[k] || rdy[k+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (rdy[k]) begin
        v[k] <= v[k-1];
      end
      if (rdy[k] && v[k-1]) begin
        ctl[k]    <= ctl[k-1];
        dv[k]     <= dv[k-1];
        rem_re[k] <= take_re ? rem_re[k-1] - t : rem_re[k-1];
        rem_im[k] <= take_im ? rem_im[k-1] - t : rem_im[k-1];
        q_re[k]   <= q_re[k-1] | (PW'(take_re) << BIT);
        q_im[k]   <= q_im[k-1] | (PW'(take_im) << BIT);
      end
    end
  end

  assign out_valid = v[NS-1];
  assign out_ctl   = ctl[NS-1];
  assign out_q_re  = q_re[NS-1];
  assign out_q_im  = q_im[NS-1];

endmodule

// File: hdl/complex_arith_unit.sv
// Complex arithmetic unit: each request carries an operation (add, subtract,
// multiply, divide) and two complex operands in signed fixed point with
// DATA_WIDTH bits, FRAC_BITS fractional. One response per request, in order:
// the saturated real and imaginary parts and a status (ok, saturated, divide
// by zero with a zero result). Multiply and divide truncate toward zero. A
// new request is taken every cycle while no stage stalls. The stages are a
// stage of multipliers, a stage of sums, DATA_WIDTH + 2 stages of restoring
// division (an entry stage, then one per quotient bit) and one output
// register. Each stage stalls only while it is full and the stage after it
// is blocked, so gaps in the stream close up during backpressure.
module complex_arith_unit #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
  input logic    clk,
  input logic    rst,
  cau_req_if.sink   req,
  cau_rsp_if.source rsp
);
  localparam int PW = 2 * DATA_WIDTH;

  // front end to divider
  logic                f_valid, f_ready;
  cau_pkg::ctl_t       f_ctl;
  logic [PW-1:0]       f_mag_re, f_mag_im, f_den;

  // divider to output stage
  logic                d_valid, d_ready;
  cau_pkg::ctl_t       d_ctl;
  logic [PW-1:0]       d_q_re, d_q_im;

  // output register
  logic                           o_valid;
  logic signed [DATA_WIDTH-1:0]   o_re, o_im;
  logic [1:0]                     o_st;

  logic [PW-1:0]                  mre, mim;
  logic                           sat_re, sat_im;
  logic [DATA_WIDTH-1:0]          r_re, r_im;

  localparam logic [PW-1:0] HALF = PW'(1) << (DATA_WIDTH - 1);
  localparam logic signed [DATA_WIDTH-1:0] MAXV = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] MINV = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  cau_front #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .kind      (req.kind),
    .a_re      (req.a_re),
    .a_im      (req.a_im),
    .b_re      (req.b_re),
    .b_im      (req.b_im),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .ctl       (f_ctl),
    .mag_re    (f_mag_re),
    .mag_im    (f_mag_im),
    .den       (f_den)
  );

  cau_div #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_ctl    (f_ctl),
    .in_mag_re (f_mag_re),
    .in_mag_im (f_mag_im),
    .in_den    (f_den),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .out_ctl   (d_ctl),
    .out_q_re  (d_q_re),
    .out_q_im  (d_q_im)
  );

  // Saturate each part: a negative part may reach HALF, a positive one
  // HALF - 1. An overflowed quotient is forced past both limits.
  always_comb begin
    mre    = d_ctl.ovf_re ? '1 : d_q_re;
    mim    = d_ctl.ovf_im ? '1 : d_q_im;
    sat_re = d_ctl.neg_re ? (mre > HALF) : (mre > HALF - PW'(1));
    sat_im = d_ctl.neg_im ? (mim > HALF) : (mim > HALF - PW'(1));
    r_re   = d_ctl.neg_re ? DATA_WIDTH'(-mre) : DATA_WIDTH'(mre);
    r_im   = d_ctl.neg_im ? DATA_WIDTH'(-mim) : DATA_WIDTH'(mim);
  end

  assign d_ready = !o_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (d_ready) begin
      o_valid <= d_valid;
    end
    if (d_ready && d_valid) begin
      if (d_ctl.zero) begin
        // zero divisor: drop the quotient, report zero
        o_re <= '0;
        o_im <= '0;
        o_st <= cau_pkg::ST_DIVZ;
      end else begin
        o_re <= sat_re ? (d_ctl.neg_re ? MINV : MAXV) : $signed(r_re);
        o_im <= sat_im ? (d_ctl.neg_im ? MINV : MAXV) : $signed(r_im);
        o_st <= (sat_re || sat_im) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end
    end
  end

  assign rsp.valid  = o_valid;
  assign rsp.res_re = o_re;
  assign rsp.res_im = o_im;
  assign rsp.status = o_st;

  a_divz_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == cau_pkg::ST_DIVZ |-> rsp.res_re == '0 && rsp.res_im == '0)
    else $error("divide by zero response carries nonzero data");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.status == cau_pkg::ST_OK || rsp.status == cau_pkg::ST_SAT ||
                  rsp.status == cau_pkg::ST_DIVZ)
    else $error("undefined status code");

  a_sat_extreme: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == cau_pkg::ST_SAT |->
      rsp.res_re == MAXV || rsp.res_re == MINV || rsp.res_im == MAXV || rsp.res_im == MINV)
    else $error("saturated status without a clamped part");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !rsp.valid)
    else $error("response valid right after reset");

  a_zero_is_div: assert property (@(posedge clk) disable iff (rst)
    d_valid && d_ctl.zero |-> d_ctl.is_div && d_q_re == '0 && d_q_im == '0)
    else $error("zero divisor flag on a non-divide or with quotient bits");

endmodule
